// File: sv/jrf_pkg.sv
// Shared types and constants for the request framer.
// No dependencies; imported by jrf_frame_core and the jvs_request_framer top.
package jrf_pkg;

	localparam logic [7:0] SYNC_RESET   = 8'hE0;
	localparam logic [7:0] ESCAPE_RESET = 8'hD0;

	// request kinds carried on tuser
	localparam logic OP_START = 1'b0;
	localparam logic OP_DATA  = 1'b1;

	// register byte addresses (decoded on paddr[2])
	localparam logic REG_SYNC   = 1'b0;
	localparam logic REG_ESCAPE = 1'b1;

	localparam int MAX_BYTES = 4;

	// line bytes produced by one request, lowest index goes out first
	typedef struct packed {
		logic [MAX_BYTES-1:0][7:0] bytes;
		logic [2:0]                count;  // 0..4
		logic                      cksum;  // last byte is the frame checksum
	} jrf_batch_t;

endpackage

// File: sv/jrf_frame_core.sv
// Frame state (bytes left, running checksum, open flag) and the logic that
// turns one request into its batch of line bytes. Depends on jrf_pkg.
module jrf_frame_core import jrf_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       take,
	input  logic       opcode,
	input  logic [7:0] dest_node,
	input  logic [7:0] payload_count,
	input  logic [7:0] payload_byte,
	input  logic [7:0] sync_value,
	input  logic [7:0] escape_value,
	output jrf_batch_t batch
);

	logic [7:0] bytes_left_q;
	logic [7:0] running_sum_q;
	logic       frame_open_q;

	logic [7:0] bytes_left_d;
	logic [7:0] running_sum_d;
	logic       frame_open_d;
	logic [7:0] len;
	logic       esc_hit;
	logic       closing;

	always_comb begin
		bytes_left_d  = bytes_left_q;
		running_sum_d = running_sum_q;
		frame_open_d  = frame_open_q;
		batch         = '0;
		len           = payload_count + 8'd1;
		esc_hit       = (payload_byte == sync_value) || (payload_byte == escape_value);
		closing       = 1'b0;
		if (opcode == OP_START) begin
			running_sum_d  = dest_node + len;
			bytes_left_d   = payload_count;
			closing        = (payload_count == 8'd0);
			frame_open_d   = !closing;
			batch.bytes[0] = sync_value;
			batch.bytes[1] = dest_node;
			batch.bytes[2] = len;
			batch.bytes[3] = running_sum_d;
			batch.count    = closing ? 3'd4 : 3'd3;
			batch.cksum    = closing;
		end else if (frame_open_q) begin
			running_sum_d = running_sum_q + payload_byte;
			bytes_left_d  = bytes_left_q - 8'd1;
			closing       = (bytes_left_d == 8'd0);
			frame_open_d  = !closing;
			if (esc_hit) begin
				batch.bytes[0] = escape_value;
				batch.bytes[1] = payload_byte - 8'd1;
				batch.bytes[2] = running_sum_d;
				batch.count    = closing ? 3'd3 : 3'd2;
			end else begin
				batch.bytes[0] = payload_byte;
				batch.bytes[1] = running_sum_d;
				batch.count    = closing ? 3'd2 : 3'd1;
			end
			batch.cksum = closing;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bytes_left_q  <= '0;
			running_sum_q <= '0;
			frame_open_q  <= 1'b0;
		end else if (take) begin
			bytes_left_q  <= bytes_left_d;
			running_sum_q <= running_sum_d;
			frame_open_q  <= frame_open_d;
		end
	end

endmodule

// File: sv/jvs_request_framer.sv
// Top level of the request framer: register port, request intake and the
// line byte serializer. Depends on jrf_pkg and jrf_frame_core.
//
// Usage:
//  - s_* stream takes requests. tuser = opcode (start or data); tdata holds
//    dest_node, payload_count and payload_byte. A start request opens a
//    frame (sync, destination, length + 1); a data request adds one payload
//    byte, escaped when it equals sync or escape. The checksum follows the
//    final payload byte, or the length byte when payload_count is 0.
//  - m_* stream gives one line byte per transfer. tuser marks the checksum
//    byte, tlast marks the last byte caused by a request.
//  - APB port: sync_value at 0x0, escape_value at 0x4. Write only while idle.
// Output: the byte batch of an accepted request is registered in batch_s1 and driven from there.
// Throughput: one line byte per cycle while m_tready is high; a request makes
// 1 to 4 bytes, and the next request is taken in the cycle the last byte of
// the current one is taken. A data request with no open frame makes no byte
// and is simply absorbed.
// Reset: both registers return to their defaults, no frame is open and the
// output holds nothing. A stalled receiver holds the current byte, and
// s_tready stays low until its final byte is taken.
module jvs_request_framer import jrf_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	// request input
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [23:0] s_tdata,   // [7:0] dest_node, [15:8] payload_count, [23:16] payload_byte
	input  logic        s_tuser,   // [0] opcode
	// line byte output
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [7:0]  m_tdata,   // [7:0] line_byte
	output logic        m_tuser,   // [0] frame_end
	output logic        m_tlast,   // run_last
	// register port
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);

	logic [7:0] sync_q;
	logic [7:0] escape_q;

	jrf_batch_t batch_nxt;
	jrf_batch_t batch_s1;   // bytes waiting on the line
	logic       valid_q;
	logic [1:0] idx_q;      // byte of batch_s1 now on m_tdata
	logic       take;
	logic       last_byte;
	logic       wr_en;

	// --- register port ---
	assign pready = 1'b1;
	assign wr_en  = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sync_q   <= SYNC_RESET;
			escape_q <= ESCAPE_RESET;
		end else if (wr_en) begin
			if (paddr[2] == REG_SYNC)
				sync_q <= pwdata[7:0];
			else
				escape_q <= pwdata[7:0];
		end
	end

	assign prdata = {24'd0, (paddr[2] == REG_ESCAPE) ? escape_q : sync_q};

	// --- request intake ---
	// Ready whenever the serializer is empty or hands off its final byte now.
	assign last_byte = ({1'b0, idx_q} == (batch_s1.count - 3'd1));
	assign s_tready  = !valid_q || (m_tready && last_byte);
	assign take      = s_tvalid && s_tready;

	jrf_frame_core u_core (
		.clk           (clk),
		.arst_n        (arst_n),
		.take          (take),
		.opcode        (s_tuser),
		.dest_node     (s_tdata[7:0]),
		.payload_count (s_tdata[15:8]),
		.payload_byte  (s_tdata[23:16]),
		.sync_value    (sync_q),
		.escape_value  (escape_q),
		.batch         (batch_nxt)
	);

	// --- serializer ---
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			idx_q   <= '0;
		end else if (take) begin
			valid_q <= (batch_nxt.count != 3'd0);
			idx_q   <= '0;
		end else if (valid_q && m_tready) begin
			if (last_byte)
				valid_q <= 1'b0;
			else
				idx_q <= idx_q + 2'd1;
		end
	end

	// payload only, no reset needed
	always_ff @(posedge clk) begin
		if (take)
			batch_s1 <= batch_nxt;
	end

	assign m_tvalid = valid_q;
	assign m_tdata  = batch_s1.bytes[idx_q];
	assign m_tlast  = last_byte;
	assign m_tuser  = batch_s1.cksum && last_byte;

	// --- checks ---
	a_batch_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		valid_q |-> (batch_s1.count != 3'd0))
		else $error("serializer holds an empty batch");

	a_idx_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		valid_q |-> ({1'b0, idx_q} < batch_s1.count))
		else $error("byte index past end of batch");

	a_idle_ready: assert property (@(posedge clk) disable iff (!arst_n)
		!valid_q |-> s_tready)
		else $error("idle serializer refuses requests");

	a_stall_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_q && !m_tready) |=> (valid_q && $stable(idx_q)))
		else $error("byte advanced while receiver stalled");

endmodule
